/* sv/uri_split_percent_decode_top_assert.svh */
// Assertion macros used by the URI splitter and percent decoder top level.
`ifndef URI_SPLIT_PERCENT_DECODE_TOP_ASSERT_SVH
`define URI_SPLIT_PERCENT_DECODE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define USP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("usp same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define USP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("usp next-cycle check failed");

`endif

/* sv/usp_pkg.sv */
// Package: scan modes, result kinds, character codes and hex digit decode.
package usp_pkg;

	typedef enum logic [2:0] {
		MODE_PATH  = 3'd0,
		MODE_ESC1  = 3'd1,
		MODE_ESC2  = 3'd2,
		MODE_QUERY = 3'd3,
		MODE_FRAG  = 3'd4,
		MODE_ERROR = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_PATH  = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

	localparam logic [7:0] CHAR_PCT   = 8'h25;
	localparam logic [7:0] CHAR_HASH  = 8'h23;
	localparam logic [7:0] CHAR_QMARK = 8'h3F;

	// One result item
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       err;
		logic       done;
	} res_t;

	// Scanner state carried from item to item
	typedef struct packed {
		mode_t      mode;
		logic [3:0] nibble;
	} scan_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// Decode one ASCII hex digit in either case
	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.val = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.val = 4'(c - 8'h41 + 8'd10);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.val = 4'(c - 8'h61 + 8'd10);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

/* sv/usp_step.sv */
// Per-byte scan step: next scanner state and the result item for one byte.
module usp_step import usp_pkg::*; (
	input  scan_t      cur,
	input  logic [7:0] uri_byte,
	input  logic       end_of_uri,
	output scan_t      nxt,
	output res_t       res
);

	hex_t  hex;
	mode_t mode;

	assign hex = hex_value(uri_byte);

	// Classify the byte against the current mode
	always_comb begin
		mode       = cur.mode;
		nxt.nibble = cur.nibble;
		res.kind   = KIND_NONE;
		res.data   = 8'h00;
		unique case (cur.mode)
			MODE_PATH: begin
				if (uri_byte == CHAR_PCT) begin
					mode = MODE_ESC1;
				end else if (uri_byte == CHAR_QMARK) begin
					mode = MODE_QUERY;
				end else if (uri_byte == CHAR_HASH) begin
					mode = MODE_FRAG;
				end else begin
					res.kind = KIND_PATH;
					res.data = uri_byte;
				end
			end
			MODE_ESC1: begin
				if (hex.ok) begin
					nxt.nibble = hex.val;
					mode       = MODE_ESC2;
				end else begin
					mode = MODE_ERROR;
				end
			end
			MODE_ESC2: begin
				if (hex.ok) begin
					res.kind = KIND_PATH;
					res.data = {cur.nibble, hex.val};
					mode     = MODE_PATH;
				end else begin
					mode = MODE_ERROR;
				end
			end
			MODE_QUERY: begin
				if (uri_byte == CHAR_HASH) begin
					mode = MODE_FRAG;
				end else begin
					res.kind = KIND_QUERY;
					res.data = uri_byte;
				end
			end
			MODE_FRAG: begin
				mode = MODE_FRAG;
			end
			default: begin
				mode = MODE_ERROR;
			end
		endcase

		// Flag an escape cut off by the end of the URI
		if (end_of_uri && (mode == MODE_ESC1 || mode == MODE_ESC2)) begin
			mode = MODE_ERROR;
		end

		res.err  = (mode == MODE_ERROR);
		res.done = end_of_uri;

		// Return to path mode for the next URI
		if (end_of_uri) begin
			nxt.mode   = MODE_PATH;
			nxt.nibble = 4'd0;
		end else begin
			nxt.mode = mode;
		end
	end

endmodule

/* sv/uri_split_percent_decode_top.sv */
// Top level: URI splitter and percent decoder with input and result registers.
//
// Usage: feed the raw bytes of a request URI on the input channel
// (in_valid/in_ready, uri_byte, end_of_uri), one byte per item, with
// end_of_uri high on the final byte. Every input item yields exactly one
// result item on the output channel (out_valid/out_ready): byte_kind tells
// whether out_byte holds a decoded path byte, a query byte or nothing;
// decode_error is sticky within one URI; done_res marks the final byte.
// An accepted item passes through the input register, then the result
// register, before out_valid rises. Throughput: one item per cycle while
// out_ready stays high; the scan state lives in a single register updated
// as each item moves from the input register to the result register.
// Reset: both stages empty, scanner in path mode. When the receiver stalls,
// the result register holds, the input register fills, and in_ready drops
// only once both are full; no item is lost or repeated.
module uri_split_percent_decode_top import usp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] uri_byte,
	input  logic       end_of_uri,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] byte_kind,
	output logic [7:0] out_byte,
	output logic       decode_error,
	output logic       done_res
);

`include "uri_split_percent_decode_top_assert.svh"

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       valid_s2;
	res_t       res_s2;
	scan_t      scan_q;
	scan_t      scan_nxt;
	res_t       res_nxt;
	logic       adv_s1;
	logic       free_s2;

	// Handshake and stage advance
	assign free_s2  = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && free_s2;
	assign in_ready = !valid_s1 || free_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= uri_byte;
			end_s1  <= end_of_uri;
		end
	end

	usp_step u_step (
		.cur        (scan_q),
		.uri_byte   (byte_s1),
		.end_of_uri (end_s1),
		.nxt        (scan_nxt),
		.res        (res_nxt)
	);

	// Scanner state advances with each item leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '{mode: MODE_PATH, nibble: 4'd0};
		end else if (adv_s1) begin
			scan_q <= scan_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid    = valid_s2;
	assign byte_kind    = res_s2.kind;
	assign out_byte     = res_s2.data;
	assign decode_error = res_s2.err;
	assign done_res     = res_s2.done;

	// Scanner restarts in path mode after the final byte
	`USP_ASSERT_NEXT(a_restart, adv_s1 && end_s1,
		scan_q.mode == MODE_PATH && scan_q.nibble == 4'd0)
	// Fragment mode holds until the end of the URI
	`USP_ASSERT_NEXT(a_frag_hold, adv_s1 && !end_s1 && scan_q.mode == MODE_FRAG,
		scan_q.mode == MODE_FRAG)
	// An errored result never carries a byte
	`USP_ASSERT_NOW(a_err_silent, valid_s2 && res_s2.err, res_s2.kind == KIND_NONE)
	// An empty result carries a zero byte
	`USP_ASSERT_NOW(a_none_zero, valid_s2 && res_s2.kind == KIND_NONE, res_s2.data == 8'h00)

endmodule

/* tb/uri_split_percent_decode_top_tb.sv */
// Testbench for the URI splitter and percent decoder: queued driver, monitor and predictor.
module uri_split_percent_decode_top_tb import usp_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 1150;

	typedef struct {
		logic [7:0] data;
		logic       eou;
		logic       drain;
		logic       hold;
	} uri_item_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] uri_byte;
	logic       end_of_uri;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] byte_kind;
	logic [7:0] out_byte;
	logic       decode_error;
	logic       done_res;

	uri_split_percent_decode_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.uri_byte     (uri_byte),
		.end_of_uri   (end_of_uri),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.byte_kind    (byte_kind),
		.out_byte     (out_byte),
		.decode_error (decode_error),
		.done_res     (done_res)
	);

	uri_item_t  uri_bytes_q[$];
	res_t       results_due_q[$];
	mode_t      scan_mode_q;
	logic [3:0] nibble_q;
	logic       in_fire;
	logic       timed_out;
	int         err_cnt;
	int         idle_cycles;
	int         hold_seq;
	int         hold_seen;
	int         tx_gap;
	int         tx_burst;
	int         rx_gap;
	int         rx_burst;
	int         rx_hold;

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hex digit value in bits 3:0; bit 4 set when the byte is not a hex digit
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) begin
			return {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			return {1'b0, 4'(c - 8'h41 + 8'd10)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			return {1'b0, 4'(c - 8'h61 + 8'd10)};
		end
		return 5'h10;
	endfunction

	// Advance the scanner by one byte and return the result it should produce
	function automatic res_t decode_step(input logic [7:0] c, input logic last);
		res_t       r;
		mode_t      mode;
		kind_t      kind;
		logic [7:0] val;
		logic [4:0] h;
		mode = scan_mode_q;
		kind = KIND_NONE;
		val  = 8'd0;
		h    = nibble_of(c);
		case (mode)
			MODE_PATH: begin
				if (c == CHAR_PCT) begin
					mode = MODE_ESC1;
				end else if (c == CHAR_QMARK) begin
					mode = MODE_QUERY;
				end else if (c == CHAR_HASH) begin
					mode = MODE_FRAG;
				end else begin
					kind = KIND_PATH;
					val  = c;
				end
			end
			MODE_ESC1: begin
				if (!h[4]) begin
					nibble_q = h[3:0];
					mode     = MODE_ESC2;
				end else begin
					mode = MODE_ERROR;
				end
			end
			MODE_ESC2: begin
				if (!h[4]) begin
					kind = KIND_PATH;
					val  = {nibble_q, h[3:0]};
					mode = MODE_PATH;
				end else begin
					mode = MODE_ERROR;
				end
			end
			MODE_QUERY: begin
				if (c == CHAR_HASH) begin
					mode = MODE_FRAG;
				end else begin
					kind = KIND_QUERY;
					val  = c;
				end
			end
			MODE_FRAG: begin
			end
			default: begin
				mode = MODE_ERROR;
			end
		endcase
		// An escape left open by the final byte is an error
		if (last && (mode == MODE_ESC1 || mode == MODE_ESC2)) begin
			mode = MODE_ERROR;
		end
		r.kind = kind;
		r.data = val;
		r.err  = (mode == MODE_ERROR);
		r.done = last;
		if (last) begin
			scan_mode_q = MODE_PATH;
			nibble_q    = 4'd0;
		end else begin
			scan_mode_q = mode;
		end
		return r;
	endfunction

	// Idle length: mostly none or short, a few long, with gap-free bursts
	function automatic int pick_gap(inout int burst);
		int r;
		if (burst > 0) begin
			burst--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			burst = $urandom_range(20, 60);
			return 0;
		end
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] rand_hex();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10) return 8'(8'h30 + v);
		if ($urandom_range(0, 1)) return 8'(8'h41 + v - 10);
		return 8'(8'h61 + v - 10);
	endfunction

	// Any byte that is not one of the three delimiters
	function automatic logic [7:0] rand_plain();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (c == CHAR_PCT || c == CHAR_QMARK || c == CHAR_HASH);
		return c;
	endfunction

	// Queue one URI; end_of_uri on its last byte, pressure marks on its first
	task automatic add_uri(input logic [7:0] b[$], input logic drain, input logic hold);
		uri_item_t it;
		foreach (b[i]) begin
			it.data  = b[i];
			it.eou   = (i == b.size() - 1);
			it.drain = drain && (i == 0);
			it.hold  = hold && (i == 0);
			uri_bytes_q.push_back(it);
		end
	endtask

	task automatic add_text(input string s);
		logic [7:0] b[$];
		for (int i = 0; i < s.len(); i++) begin
			b.push_back(s[i]);
		end
		add_uri(b, 1'b0, 1'b0);
	endtask

	// Check result items against predictions, predict accepted items, watch for hangs
	always @(posedge clk) begin
		res_t want;
		in_fire <= arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (results_due_q.size() == 0) begin
					$error("unexpected result item: byte_kind %0d out_byte %0d", byte_kind,
						out_byte);
					err_cnt++;
				end else begin
					want = results_due_q.pop_front();
					if (byte_kind !== want.kind) begin
						$error("byte_kind: expected %0d, actual %0d", want.kind, byte_kind);
						err_cnt++;
					end
					if (out_byte !== want.data) begin
						$error("out_byte: expected %0d, actual %0d", want.data, out_byte);
						err_cnt++;
					end
					if (decode_error !== want.err) begin
						$error("decode_error: expected %0d, actual %0d", want.err,
							decode_error);
						err_cnt++;
					end
					if (done_res !== want.done) begin
						$error("done_res: expected %0d, actual %0d", want.done, done_res);
						err_cnt++;
					end
				end
			end
			if (in_valid && in_ready) begin
				results_due_q.push_back(decode_step(uri_byte, end_of_uri));
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
			end
		end
	end

	// Drive input items from the pending queue
	always @(negedge clk) begin
		uri_item_t it;
		logic      nxt_valid;
		logic      load;
		nxt_valid = in_valid;
		load      = 1'b0;
		if (arst_n && (!in_valid || in_fire)) begin
			nxt_valid = 1'b0;
			if (tx_gap != 0) begin
				tx_gap--;
			end else if (uri_bytes_q.size() != 0 &&
				!(uri_bytes_q[0].drain && results_due_q.size() != 0)) begin
				it        = uri_bytes_q.pop_front();
				nxt_valid = 1'b1;
				load      = 1'b1;
				tx_gap    = pick_gap(tx_burst);
				// Ask the receiver for a long hold-off while items keep coming
				if (it.hold) begin
					tx_gap   = 0;
					tx_burst = 2 * HOLD_CYCLES;
					hold_seq <= hold_seq + 1;
				end
			end
		end
		in_valid <= nxt_valid;
		if (load) begin
			uri_byte   <= it.data;
			end_of_uri <= it.eou;
		end
	end

	// Drive out_ready: random gaps, and a long hold-off on request
	always @(negedge clk) begin
		logic nxt_ready;
		nxt_ready = 1'b0;
		if (arst_n) begin
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				rx_hold   = HOLD_CYCLES;
			end
			if (rx_hold != 0) begin
				rx_hold--;
			end else if (rx_gap != 0) begin
				rx_gap--;
			end else begin
				nxt_ready = 1'b1;
				rx_gap    = pick_gap(rx_burst);
			end
		end
		out_ready <= nxt_ready;
	end

	// Build stimulus, run reset, wait for the drain, report
	initial begin
		logic [7:0] b[$];
		int         n_items;
		int         uri_n;
		int         style;
		int         r;
		in_valid    = 1'b0;
		uri_byte    = 8'd0;
		end_of_uri  = 1'b0;
		out_ready   = 1'b0;
		arst_n      = 1'b0;
		in_fire     = 1'b0;
		timed_out   = 1'b0;
		err_cnt     = 0;
		idle_cycles = 0;
		hold_seq    = 0;
		hold_seen   = 0;
		tx_gap      = 0;
		tx_burst    = 0;
		rx_gap      = 0;
		rx_burst    = 0;
		rx_hold     = 0;
		scan_mode_q = MODE_PATH;
		nibble_q    = 4'd0;

		// Directed: escapes in both cases, query split, fragment, broken and cut escapes
		add_text("/a%2Fb?x%41#f");
		add_text("%aF");
		add_text("%Gx");
		add_text("%4");
		add_text("#?");
		b = '{8'h00, 8'hFF};
		add_uri(b, 1'b0, 1'b0);

		// Random URIs: mostly well formed, some noise and broken escapes
		n_items = 0;
		uri_n   = 0;
		while (n_items < RANDOM_ITEMS) begin
			b.delete();
			style = $urandom_range(0, 9);
			if (style == 0) begin
				repeat ($urandom_range(1, 16)) begin
					r = $urandom_range(0, 5);
					if (r == 0) b.push_back(CHAR_PCT);
					else if (r == 1) b.push_back(CHAR_QMARK);
					else if (r == 2) b.push_back(CHAR_HASH);
					else if (r == 3) b.push_back(rand_hex());
					else b.push_back(8'($urandom_range(0, 255)));
				end
			end else begin
				repeat ($urandom_range(0, 8)) begin
					if ($urandom_range(0, 3) == 0) begin
						b.push_back(CHAR_PCT);
						b.push_back(rand_hex());
						b.push_back(rand_hex());
					end else begin
						b.push_back(rand_plain());
					end
				end
				// Leave an escape open, to be cut by a delimiter, a bad digit or the end
				if (style == 1) begin
					b.push_back(CHAR_PCT);
					if ($urandom_range(0, 1)) b.push_back(rand_hex());
					if ($urandom_range(0, 2) == 0) b.push_back(rand_plain());
				end
				if ($urandom_range(0, 2) != 0) begin
					b.push_back(CHAR_QMARK);
					repeat ($urandom_range(0, 8)) begin
						if ($urandom_range(0, 4) == 0) b.push_back(CHAR_PCT);
						else b.push_back(rand_plain());
					end
				end
				if ($urandom_range(0, 3) == 0) begin
					b.push_back(CHAR_HASH);
					repeat ($urandom_range(0, 4)) b.push_back(8'($urandom_range(0, 255)));
				end
			end
			if (b.size() == 0) b.push_back(rand_plain());
			add_uri(b, uri_n == 40 || uri_n == 110, uri_n == 20 || uri_n == 80);
			n_items += b.size();
			uri_n++;
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (!timed_out && (uri_bytes_q.size() != 0 || in_valid ||
			results_due_q.size() != 0)) begin
			@(posedge clk);
		end
		if (timed_out) begin
			$display("uri_split_percent_decode_top_tb failed");
		end else begin
			repeat (8) @(posedge clk);
			if (err_cnt == 0 && results_due_q.size() == 0) begin
				$display("uri_split_percent_decode_top_tb passed");
			end else begin
				$display("uri_split_percent_decode_top_tb failed");
			end
		end
		$finish;
	end

endmodule
